FILE: hw/rtl/pn3d_pkg.sv
package pn3d_pkg;

  // Permutation table geometry: cell indexes wrap modulo the table depth
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = 8;

  // Port widths
  localparam int COORD_W  = 32;
  localparam int NOISE_W  = 18;
  localparam int OUT_FRAC = 16;

  // Saturation bounds of the result
  localparam int NOISE_MAX = 131071;
  localparam int NOISE_MIN = -131072;

  // Request function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  // Gradient selection thresholds on the low four hash bits
  localparam logic [3:0] HASH_U_Y  = 4'd8;
  localparam logic [3:0] HASH_V_Y  = 4'd4;
  localparam logic [3:0] HASH_V_XA = 4'd12;
  localparam logic [3:0] HASH_V_XB = 4'd14;

endpackage

FILE: hw/rtl/perlin_noise_3d.sv
// Improved 3D gradient noise on signed fixed-point coordinates with FRAC_BITS
// fraction bits. A request with func_i = 0 loads one entry of the 256-entry
// permutation table and returns nothing; busy stays low. A request with
// func_i = 1 evaluates noise at (coord_x_i, coord_y_i, coord_z_i) and
// returns one 18-bit signed result with 16 fraction bits, saturated. Every
// table entry that a point hashes to must be loaded before that point is
// evaluated; the table has no reset value and no clearing pass. An evaluation
// keeps busy high until its result is ready and raises done_o in the cycle in
// which busy falls; no new evaluation or write is taken while busy is high.
// Its pace is set by the single shared multiplier: the three quintic fades and
// the seven lerps make 19 dependent multiplies, each passing through operand
// setup, multiply, and round and accumulate. The 14 table reads run alongside
// the fades on the table's one read port. The result is on noise_value_o from
// the done_o cycle until the next evaluation ends; the receiver cannot stall
// it, so capture it then. A new request may be accepted in that same cycle.
module perlin_noise_3d #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    func_i,
  input  logic        [pn3d_pkg::IDX_W-1:0]       table_index_i,
  input  logic        [pn3d_pkg::IDX_W-1:0]       table_value_i,
  input  logic signed [pn3d_pkg::COORD_W-1:0]     coord_x_i,
  input  logic signed [pn3d_pkg::COORD_W-1:0]     coord_y_i,
  input  logic signed [pn3d_pkg::COORD_W-1:0]     coord_z_i,
  output logic                                    done_o,
  output logic signed [pn3d_pkg::NOISE_W-1:0]     noise_value_o
);

  localparam int IW = pn3d_pkg::IDX_W;
  localparam int NW = pn3d_pkg::NOISE_W;
  localparam int FW = FRAC_BITS;
  localparam int TW = FRAC_BITS + 2;  // fade weight, signed
  localparam int OW = FRAC_BITS + 6;  // multiplier operand and accumulator
  localparam int PW = TW + OW;        // product
  localparam int GW = FRAC_BITS + 3;  // gradient dot product
  localparam int VW = FRAC_BITS + 4;  // lerp results
  localparam int SW = VW + pn3d_pkg::OUT_FRAC + 1;
  localparam int SHL = (FRAC_BITS < pn3d_pkg::OUT_FRAC) ? pn3d_pkg::OUT_FRAC - FRAC_BITS : 0;
  localparam int SHR = (FRAC_BITS > pn3d_pkg::OUT_FRAC) ? FRAC_BITS - pn3d_pkg::OUT_FRAC : 0;

  localparam logic signed [OW-1:0] C15_O  = OW'(15) << FRAC_BITS;
  localparam logic signed [OW-1:0] C10_O  = OW'(10) << FRAC_BITS;
  localparam logic signed [GW-1:0] ONE_G  = GW'(1) << FRAC_BITS;
  localparam logic signed [PW-1:0] HALF_P = (PW'(1) << FRAC_BITS) >> 1;
  localparam logic signed [SW-1:0] HALF_S = (SW'(1) << SHR) >> 1;
  localparam logic signed [SW-1:0] SAT_MAX = SW'(pn3d_pkg::NOISE_MAX);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(pn3d_pkg::NOISE_MIN);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  // Phases of one multiply operation
  localparam logic [1:0] PH_PREP = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_WB   = 2'd2;

  // Multiply operations: four per fade (x, y, z), then the seven lerps
  localparam logic [4:0] OP_FADE_FIRST = 5'd0;
  localparam logic [4:0] OP_FADE_LAST  = 5'd11;
  localparam logic [4:0] OP_L00 = 5'd12;
  localparam logic [4:0] OP_L10 = 5'd13;
  localparam logic [4:0] OP_L01 = 5'd14;
  localparam logic [4:0] OP_L11 = 5'd15;
  localparam logic [4:0] OP_M0  = 5'd16;
  localparam logic [4:0] OP_M1  = 5'd17;
  localparam logic [4:0] OP_R   = 5'd18;
  localparam logic [1:0] FADE_STEP_LAST = 2'd3;

  // Fade selectors
  localparam logic [1:0] FADE_X = 2'd0;
  localparam logic [1:0] FADE_Y = 2'd1;
  localparam logic [1:0] FADE_Z = 2'd2;

  // Lerp result slots
  localparam logic [2:0] LV_L00 = 3'd0;
  localparam logic [2:0] LV_L10 = 3'd1;
  localparam logic [2:0] LV_L01 = 3'd2;
  localparam logic [2:0] LV_L11 = 3'd3;
  localparam logic [2:0] LV_M0  = 3'd4;
  localparam logic [2:0] LV_M1  = 3'd5;
  localparam logic [2:0] LV_R   = 3'd6;

  // Table read schedule
  localparam logic [3:0] RD_X0   = 4'd0;
  localparam logic [3:0] RD_X1   = 4'd1;
  localparam logic [3:0] RD_A0   = 4'd2;
  localparam logic [3:0] RD_A1   = 4'd3;
  localparam logic [3:0] RD_B0   = 4'd4;
  localparam logic [3:0] RD_B1   = 4'd5;
  localparam logic [3:0] RD_AA0  = 4'd6;
  localparam logic [3:0] RD_AA1  = 4'd7;
  localparam logic [3:0] RD_AB0  = 4'd8;
  localparam logic [3:0] RD_AB1  = 4'd9;
  localparam logic [3:0] RD_BA0  = 4'd10;
  localparam logic [3:0] RD_BA1  = 4'd11;
  localparam logic [3:0] RD_BB0  = 4'd12;
  localparam logic [3:0] RD_BB1  = 4'd13;
  localparam logic [3:0] RD_LAST = 4'd14;
  localparam logic [3:0] RD_DONE = 4'd15;

  // Control
  logic [1:0] state_q;
  logic [4:0] op_q;
  logic [1:0] ph_q;
  logic [3:0] rd_q;
  logic       done_q;
  logic       acc_eval;
  logic       tbl_we;
  logic       tbl_re;

  // Table
  logic [IW-1:0] mem_q [pn3d_pkg::TABLE_SIZE];
  logic [IW-1:0] rdata_q;
  logic [IW-1:0] raddr;

  // Point and hash registers
  logic [FW-1:0] fx_q, fy_q, fz_q;
  logic [IW-1:0] cx_q, cy_q, cz_q;
  logic [IW-1:0] a_q, b_q, aa_q, ab_q, ba_q, bb_q;
  logic signed [GW-1:0] g_q [8];

  // Arithmetic unit
  logic signed [TW-1:0] fd_q [3];
  logic signed [OW-1:0] acc_q;
  logic signed [VW-1:0] lv_q [7];
  logic signed [TW-1:0] t_q, t_d;
  logic signed [OW-1:0] opnd_q, opnd_d;
  logic signed [OW-1:0] addv_q, addv_d;
  logic signed [PW-1:0] prod_q;
  logic signed [PW-1:0] rnd;
  logic signed [PW-1:0] res;

  // Gradient of the current corner
  logic [2:0]           gidx;
  logic [3:0]           hsh;
  logic signed [GW-1:0] gxs, gys, gzs, gu, gv, grad;

  // Output scaling
  logic signed [SW-1:0]  scaled;
  logic signed [NW-1:0]  noise_d;
  logic signed [NW-1:0]  noise_q;

  // Fade operand
  logic [FW-1:0]        ff;
  logic signed [OW-1:0] ffo;

  assign acc_eval = start && !busy && (func_i == pn3d_pkg::FUNC_EVAL);
  assign tbl_we   = start && !busy && (func_i == pn3d_pkg::FUNC_WRITE);
  assign tbl_re   = (state_q == ST_RUN);
  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign noise_value_o = noise_q;

  // Sequence the operations of one evaluation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_FADE_FIRST;
      ph_q    <= PH_PREP;
      rd_q    <= RD_DONE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (acc_eval) begin
            state_q <= ST_RUN;
            op_q    <= OP_FADE_FIRST;
            ph_q    <= PH_PREP;
            rd_q    <= RD_X0;
          end
        end
        ST_RUN: begin
          if (rd_q != RD_DONE) begin
            rd_q <= rd_q + 4'd1;
          end
          unique case (ph_q)
            PH_PREP: ph_q <= PH_MUL;
            PH_MUL:  ph_q <= PH_WB;
            PH_WB: begin
              ph_q <= PH_PREP;
              if (op_q == OP_R) begin
                state_q <= ST_OUT;
              end else begin
                op_q <= op_q + 5'd1;
              end
            end
            default: ph_q <= PH_PREP;
          endcase
        end
        ST_OUT: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Select the table read address for each read step
  always_comb begin
    unique case (rd_q)
      RD_X0:   raddr = cx_q;
      RD_X1:   raddr = cx_q + IW'(1);
      RD_A0:   raddr = a_q;
      RD_A1:   raddr = a_q + IW'(1);
      RD_B0:   raddr = b_q;
      RD_B1:   raddr = b_q + IW'(1);
      RD_AA0:  raddr = aa_q;
      RD_AA1:  raddr = aa_q + IW'(1);
      RD_AB0:  raddr = ab_q;
      RD_AB1:  raddr = ab_q + IW'(1);
      RD_BA0:  raddr = ba_q;
      RD_BA1:  raddr = ba_q + IW'(1);
      RD_BB0:  raddr = bb_q;
      RD_BB1:  raddr = bb_q + IW'(1);
      default: raddr = bb_q;
    endcase
  end

  // Write and read the permutation table
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      mem_q[table_index_i] <= table_value_i;
    end
    if (tbl_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Form the gradient dot product of the corner hash just read
  always_comb begin
    gidx = 3'(rd_q - RD_AA1);
    hsh  = rdata_q[3:0];
    gxs  = gidx[2] ? ($signed({3'b000, fx_q}) - ONE_G) : $signed({3'b000, fx_q});
    gys  = gidx[1] ? ($signed({3'b000, fy_q}) - ONE_G) : $signed({3'b000, fy_q});
    gzs  = gidx[0] ? ($signed({3'b000, fz_q}) - ONE_G) : $signed({3'b000, fz_q});
    gu   = (hsh < pn3d_pkg::HASH_U_Y) ? gxs : gys;
    if (hsh < pn3d_pkg::HASH_V_Y) begin
      gv = gys;
    end else if (hsh == pn3d_pkg::HASH_V_XA || hsh == pn3d_pkg::HASH_V_XB) begin
      gv = gxs;
    end else begin
      gv = gzs;
    end
    grad = (hsh[0] ? -gu : gu) + (hsh[1] ? -gv : gv);
  end

  // Set up the operands of the current multiply
  always_comb begin
    t_d    = '0;
    opnd_d = '0;
    addv_d = '0;
    case (op_q[3:2])
      FADE_X:  ff = fx_q;
      FADE_Y:  ff = fy_q;
      default: ff = fz_q;
    endcase
    ffo = $signed({6'b000000, ff});
    unique case (op_q) inside
      [OP_FADE_FIRST:OP_FADE_LAST]: begin
        t_d = $signed({2'b00, ff});
        if (op_q[1:0] == 2'd0) begin
          opnd_d = (ffo <<< 2) + (ffo <<< 1) - C15_O;
          addv_d = C10_O;
        end else begin
          opnd_d = acc_q;
        end
      end
      OP_L00: begin
        t_d    = fd_q[FADE_X];
        opnd_d = OW'(g_q[4]) - OW'(g_q[0]);
        addv_d = OW'(g_q[0]);
      end
      OP_L10: begin
        t_d    = fd_q[FADE_X];
        opnd_d = OW'(g_q[6]) - OW'(g_q[2]);
        addv_d = OW'(g_q[2]);
      end
      OP_L01: begin
        t_d    = fd_q[FADE_X];
        opnd_d = OW'(g_q[5]) - OW'(g_q[1]);
        addv_d = OW'(g_q[1]);
      end
      OP_L11: begin
        t_d    = fd_q[FADE_X];
        opnd_d = OW'(g_q[7]) - OW'(g_q[3]);
        addv_d = OW'(g_q[3]);
      end
      OP_M0: begin
        t_d    = fd_q[FADE_Y];
        opnd_d = OW'(lv_q[LV_L10]) - OW'(lv_q[LV_L00]);
        addv_d = OW'(lv_q[LV_L00]);
      end
      OP_M1: begin
        t_d    = fd_q[FADE_Y];
        opnd_d = OW'(lv_q[LV_L11]) - OW'(lv_q[LV_L01]);
        addv_d = OW'(lv_q[LV_L01]);
      end
      OP_R: begin
        t_d    = fd_q[FADE_Z];
        opnd_d = OW'(lv_q[LV_M1]) - OW'(lv_q[LV_M0]);
        addv_d = OW'(lv_q[LV_M0]);
      end
      default: begin
        t_d = '0;
      end
    endcase
  end

  // Round the product to nearest, ties up, and add the offset
  assign rnd = (prod_q + HALF_P) >>> FRAC_BITS;
  assign res = rnd + PW'(addv_q);

  // Scale to 16 fraction bits and saturate
  always_comb begin
    scaled = ((SW'(lv_q[LV_R]) <<< SHL) + HALF_S) >>> SHR;
    if (scaled > SAT_MAX) begin
      noise_d = NW'(SAT_MAX);
    end else if (scaled < SAT_MIN) begin
      noise_d = NW'(SAT_MIN);
    end else begin
      noise_d = NW'(scaled);
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    // latch the point: fraction and cell modulo the table depth
    if (acc_eval) begin
      fx_q <= coord_x_i[FW-1:0];
      fy_q <= coord_y_i[FW-1:0];
      fz_q <= coord_z_i[FW-1:0];
      cx_q <= coord_x_i[FW+IW-1:FW];
      cy_q <= coord_y_i[FW+IW-1:FW];
      cz_q <= coord_z_i[FW+IW-1:FW];
    end

    // capture hashes and corner gradients as reads return
    if (state_q == ST_RUN) begin
      unique case (rd_q)
        RD_X1:  a_q  <= rdata_q + cy_q;
        RD_A0:  b_q  <= rdata_q + cy_q;
        RD_A1:  aa_q <= rdata_q + cz_q;
        RD_B0:  ab_q <= rdata_q + cz_q;
        RD_B1:  ba_q <= rdata_q + cz_q;
        RD_AA0: bb_q <= rdata_q + cz_q;
        RD_AA1, RD_AB0, RD_AB1, RD_BA0, RD_BA1, RD_BB0, RD_BB1, RD_LAST: begin
          g_q[gidx] <= grad;
        end
        default: begin
          a_q <= a_q;
        end
      endcase

      // advance the shared multiplier
      unique case (ph_q)
        PH_PREP: begin
          t_q    <= t_d;
          opnd_q <= opnd_d;
          addv_q <= addv_d;
        end
        PH_MUL: prod_q <= PW'(t_q) * PW'(opnd_q);
        PH_WB: begin
          if (op_q <= OP_FADE_LAST) begin
            if (op_q[1:0] == FADE_STEP_LAST) begin
              fd_q[op_q[3:2]] <= TW'(res);
            end else begin
              acc_q <= OW'(res);
            end
          end else begin
            lv_q[3'(op_q - OP_L00)] <= VW'(res);
          end
        end
        default: begin
          prod_q <= prod_q;
        end
      endcase
    end

    // hold the result for its strobe cycle
    if (state_q == ST_OUT) begin
      noise_q <= noise_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe held longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && op_q == OP_L00) |-> (rd_q == RD_DONE))
    else $error("lerps started before all corner gradients were read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("evaluation ended without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_eval |=> (busy && !done_o))
    else $error("accepted evaluation did not start the sequencer");
`endif

endmodule

FILE: tb/perlin_noise_3d_test.sv
module perlin_noise_3d_test;

  localparam int FRAC_BITS    = 16;
  localparam int RANDOM_ITEMS = 580;
  localparam int CALM_ITEMS   = 100;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 600000;

  localparam int IDX_W      = pn3d_pkg::IDX_W;
  localparam int TABLE_SIZE = pn3d_pkg::TABLE_SIZE;
  localparam int COORD_W    = pn3d_pkg::COORD_W;
  localparam int NOISE_W    = pn3d_pkg::NOISE_W;
  localparam int OUT_FRAC   = pn3d_pkg::OUT_FRAC;
  localparam int NOISE_MAX  = pn3d_pkg::NOISE_MAX;
  localparam int NOISE_MIN  = pn3d_pkg::NOISE_MIN;

  // Track the permutation table and the noise values still owed by the block
  class noise_scoreboard;
    logic [IDX_W-1:0] perm [TABLE_SIZE];
    logic signed [NOISE_W-1:0] expected_noise [$];
    int errors = 0;

    function longint qmul(longint a, longint b);
      longint p;
      p = a * b + (longint'(1) << (FRAC_BITS - 1));
      return p >>> FRAC_BITS;
    endfunction

    // Quintic fade by Horner's rule, rounding after each product
    function longint fade(longint t);
      longint one;
      longint r;
      one = longint'(1) << FRAC_BITS;
      r = t * 6 - 15 * one;
      r = qmul(t, r) + 10 * one;
      r = qmul(t, r);
      r = qmul(t, r);
      return qmul(t, r);
    endfunction

    function longint lerp(longint t, longint a, longint b);
      return a + qmul(t, b - a);
    endfunction

    function longint grad(logic [IDX_W-1:0] hash, longint x, longint y, longint z);
      logic [3:0] h;
      longint u;
      longint v;
      h = hash[3:0];
      u = (h < pn3d_pkg::HASH_U_Y) ? x : y;
      v = (h < pn3d_pkg::HASH_V_Y) ? y :
          ((h == pn3d_pkg::HASH_V_XA || h == pn3d_pkg::HASH_V_XB) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    function logic [IDX_W-1:0] tab(logic [IDX_W-1:0] i);
      return perm[i];
    endfunction

    function logic signed [NOISE_W-1:0] predict_noise(logic signed [COORD_W-1:0] px,
                                                      logic signed [COORD_W-1:0] py,
                                                      logic signed [COORD_W-1:0] pz);
      logic [IDX_W-1:0] cx, cy, cz, a, b, aa, ab, ba, bb;
      longint one, fx, fy, fz, x1, y1, z1, u, v, w;
      longint l00, l10, l01, l11, m0, m1, r;
      one = longint'(1) << FRAC_BITS;
      // Split into lattice cell (mod table size) and fractional offset
      fx = longint'(px) & (one - 1);
      fy = longint'(py) & (one - 1);
      fz = longint'(pz) & (one - 1);
      cx = IDX_W'(px >>> FRAC_BITS);
      cy = IDX_W'(py >>> FRAC_BITS);
      cz = IDX_W'(pz >>> FRAC_BITS);
      x1 = fx - one;
      y1 = fy - one;
      z1 = fz - one;
      u = fade(fx);
      v = fade(fy);
      w = fade(fz);
      // Hash the cube corners, every index wrapping at the table size
      a  = tab(cx) + cy;
      aa = tab(a) + cz;
      ab = tab(IDX_W'(a + 1)) + cz;
      b  = tab(IDX_W'(cx + 1)) + cy;
      ba = tab(b) + cz;
      bb = tab(IDX_W'(b + 1)) + cz;
      // Blend gradients with trilinear lerps
      l00 = lerp(u, grad(tab(aa), fx, fy, fz), grad(tab(ba), x1, fy, fz));
      l10 = lerp(u, grad(tab(ab), fx, y1, fz), grad(tab(bb), x1, y1, fz));
      l01 = lerp(u, grad(tab(IDX_W'(aa + 1)), fx, fy, z1),
                 grad(tab(IDX_W'(ba + 1)), x1, fy, z1));
      l11 = lerp(u, grad(tab(IDX_W'(ab + 1)), fx, y1, z1),
                 grad(tab(IDX_W'(bb + 1)), x1, y1, z1));
      m0 = lerp(v, l00, l10);
      m1 = lerp(v, l01, l11);
      r = lerp(w, m0, m1);
      // Scale to the output fraction and saturate
      if (FRAC_BITS > OUT_FRAC) begin
        r = (r + (longint'(1) << (FRAC_BITS - OUT_FRAC - 1))) >>> (FRAC_BITS - OUT_FRAC);
      end else if (FRAC_BITS < OUT_FRAC) begin
        r = r * (longint'(1) << (OUT_FRAC - FRAC_BITS));
      end
      if (r > NOISE_MAX) r = NOISE_MAX;
      if (r < NOISE_MIN) r = NOISE_MIN;
      return NOISE_W'(r);
    endfunction

    function void note_request(logic func, logic [IDX_W-1:0] idx, logic [IDX_W-1:0] val,
                               logic signed [COORD_W-1:0] px,
                               logic signed [COORD_W-1:0] py,
                               logic signed [COORD_W-1:0] pz);
      if (func == pn3d_pkg::FUNC_WRITE) begin
        perm[idx] = val;
      end else begin
        expected_noise.push_back(predict_noise(px, py, pz));
      end
    endfunction

    function void check_result(logic signed [NOISE_W-1:0] actual);
      logic signed [NOISE_W-1:0] want;
      if (expected_noise.size() == 0) begin
        $display("%0t: unexpected noise result, expected none, actual %0d", $time, actual);
        errors++;
      end else begin
        want = expected_noise.pop_front();
        if (actual !== want) begin
          $display("%0t: noise_value mismatch, expected %0d, actual %0d", $time, want, actual);
          errors++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic func_i;
  logic [IDX_W-1:0] table_index_i;
  logic [IDX_W-1:0] table_value_i;
  logic signed [COORD_W-1:0] coord_x_i;
  logic signed [COORD_W-1:0] coord_y_i;
  logic signed [COORD_W-1:0] coord_z_i;
  logic done_o;
  logic signed [NOISE_W-1:0] noise_value_o;

  noise_scoreboard sb = new();
  int cycle_count = 0;
  bit idle_on = 1'b1;

  perlin_noise_3d #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .table_index_i(table_index_i),
    .table_value_i(table_value_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .coord_z_i    (coord_z_i),
    .done_o       (done_o),
    .noise_value_o(noise_value_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Capture each result in its strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(noise_value_o);
  end

  // Present one request and hold it until the block takes it
  task automatic send_request(logic func, logic [IDX_W-1:0] idx, logic [IDX_W-1:0] val,
                              logic signed [COORD_W-1:0] px,
                              logic signed [COORD_W-1:0] py,
                              logic signed [COORD_W-1:0] pz);
    @(negedge clk_i);
    start         = 1'b1;
    func_i        = func;
    table_index_i = idx;
    table_value_i = val;
    coord_x_i     = px;
    coord_y_i     = py;
    coord_z_i     = pz;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(func, idx, val, px, py, pz);
  endtask

  task automatic send_write(logic [IDX_W-1:0] idx, logic [IDX_W-1:0] val);
    send_request(pn3d_pkg::FUNC_WRITE, idx, val, COORD_W'($urandom), COORD_W'($urandom),
                 COORD_W'($urandom));
  endtask

  task automatic send_eval(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py,
                           logic signed [COORD_W-1:0] pz);
    send_request(pn3d_pkg::FUNC_EVAL, IDX_W'($urandom), IDX_W'($urandom), px, py, pz);
  endtask

  // Drop start for a random burst now and then
  task automatic maybe_idle();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 9)) begin
        @(negedge clk_i);
        start = 1'b0;
      end
    end
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord();
    logic [COORD_W-1:0] raw;
    logic [COORD_W-1:0] frac_mask;
    raw = $urandom;
    frac_mask = (COORD_W'(1) << FRAC_BITS) - 1;
    case ($urandom_range(0, 5))
      0: return raw & ~frac_mask;
      1: return raw | frac_mask;
      2: return (raw & ~frac_mask) | COORD_W'(1);
      3: return COORD_W'($urandom_range(0, 1 << (FRAC_BITS + 2))) -
                COORD_W'(1 << (FRAC_BITS + 1));
      default: return raw;
    endcase
  endfunction

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    func_i        = pn3d_pkg::FUNC_WRITE;
    table_index_i = '0;
    table_value_i = '0;
    coord_x_i     = '0;
    coord_y_i     = '0;
    coord_z_i     = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Load every table entry before any point is evaluated
    for (int i = 0; i < TABLE_SIZE; i++) begin
      send_write(IDX_W'(i), IDX_W'($urandom));
      maybe_idle();
    end

    // Directed: table extremes, coordinate extremes, cell wrap and fraction edges
    send_write(8'd0, 8'd255);
    send_write(8'd255, 8'd0);
    send_eval(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
    send_eval(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_eval(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_eval(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFF);
    send_eval(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000);
    send_eval(32'sh0000_FFFF, 32'sh0001_0000, 32'sh0000_0001);
    send_eval(32'sh00FF_8000, 32'sh00FF_0000, 32'sh00FF_FFFF);
    send_eval(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000);
    send_write(8'hA5, 8'h5A);
    send_write(8'h5A, 8'hFF);
    send_eval(32'shFFFF_8000, 32'sh0000_4000, 32'shFFFF_C000);
    send_eval(32'sh1234_5678, 32'shEDCB_A987, 32'sh0F0F_0F0F);
    send_write(8'd0, 8'd0);
    send_write(8'd255, 8'd255);
    send_eval(32'sh00FF_FFFF, 32'sh0000_0000, 32'sh00FF_0001);
    send_eval(32'sh8000_FFFF, 32'sh7FFF_0000, 32'shFF00_0000);
    send_eval(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);

    // Random mix of table writes and evaluations; calm tail without idling
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_on = (n < RANDOM_ITEMS - CALM_ITEMS);
      if ($urandom_range(0, 9) < 3) begin
        send_write(IDX_W'($urandom), IDX_W'($urandom));
      end else begin
        send_eval(pick_coord(), pick_coord(), pick_coord());
      end
      maybe_idle();
    end

    @(negedge clk_i);
    start = 1'b0;

    // Drain outstanding results, then watch for strays
    while (sb.expected_noise.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0 && sb.expected_noise.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: perlin_noise_3d.f
hw/rtl/pn3d_pkg.sv
hw/rtl/perlin_noise_3d.sv
tb/perlin_noise_3d_test.sv
